// ===== sv/char_lcd_nibble_command_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Character LCD sequencer assertion macros
// Assertion shorthands for the bus sequencer module.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_COMMAND_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_COMMAND_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CLCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Character LCD sequencer package
// Request codes, instruction bytes, queue entry type and row offsets.
// ----------------------------------------------------------------------------
package clcd_pkg;

  localparam int TICK_W = 22;
  localparam int HOLD_W = 23;
  localparam int STEP_W = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int COLUMNS_DEFAULT = 20;
  localparam int ROWS_DEFAULT = 4;

  // Configuration register indexes.
  localparam logic [1:0] REG_PULSE   = 2'd0;
  localparam logic [1:0] REG_COMMAND = 2'd1;
  localparam logic [1:0] REG_CLEAR   = 2'd2;

  localparam logic [TICK_W-1:0] PULSE_RESET   = 22'd500;
  localparam logic [TICK_W-1:0] COMMAND_RESET = 22'd50000;
  localparam logic [TICK_W-1:0] CLEAR_RESET   = 22'd1500000;

  typedef enum logic [3:0] {
    CMD_INIT          = 4'd0,
    CMD_CLEAR         = 4'd1,
    CMD_HOME          = 4'd2,
    CMD_ENTRY         = 4'd3,
    CMD_DISPLAY       = 4'd4,
    CMD_CURSOR_SHIFT  = 4'd5,
    CMD_DISPLAY_SHIFT = 4'd6,
    CMD_POSITION      = 4'd7,
    CMD_DDRAM         = 4'd8,
    CMD_CGRAM         = 4'd9,
    CMD_DATA          = 4'd10,
    CMD_FUNCTION_SET  = 4'd11
  } cmd_t;

  // Instruction bytes and bases.
  localparam logic [7:0] INS_CLEAR         = 8'h01;
  localparam logic [7:0] INS_HOME          = 8'h02;
  localparam logic [7:0] INS_ENTRY         = 8'h04;
  localparam logic [7:0] INS_ENTRY_INIT    = 8'h06;
  localparam logic [7:0] INS_DISPLAY       = 8'h08;
  localparam logic [7:0] INS_DISPLAY_ON    = 8'h0C;
  localparam logic [7:0] INS_CURSOR_SHIFT  = 8'h10;
  localparam logic [7:0] INS_DISPLAY_SHIFT = 8'h18;
  localparam logic [7:0] INS_FUNCTION_SET  = 8'h2A;
  localparam logic [7:0] INS_CGRAM         = 8'h40;
  localparam logic [7:0] INS_DDRAM         = 8'h80;

  // Wake-up nibbles of the init sequence.
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_WAKE_LAST = 4'h2;

  // Wake-up phase count of init, and last step index of full init and of one byte.
  localparam logic [STEP_W-1:0] WAKE_PHASES    = 5'd8;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 5'd23;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 5'd3;

  // Index of the clear instruction among the four init bytes.
  localparam logic [1:0] INIT_CLEAR_SLOT = 2'd2;

  // One classified request waiting for the bus sequencer.
  typedef struct packed {
    logic       init;
    logic       rs;
    logic       clear_wait;
    logic [7:0] data;
  } job_t;

  // DDRAM start address of each screen row.
  function automatic logic [6:0] row_offset(input logic [1:0] idx);
    logic [6:0] r;
    unique case (idx)
      2'd0: r = 7'h00;
      2'd1: r = 7'h40;
      2'd2: r = 7'h14;
      2'd3: r = 7'h54;
      default: r = 7'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/clcd_if.sv =====
// ----------------------------------------------------------------------------
// Character LCD sequencer channels
// Request channel and bus phase channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface clcd_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [2:0] row;
  logic [4:0] column;
  logic [7:0] value;
  logic       flag_a;
  logic       flag_b;
  logic [1:0] cursor_mode;

  modport source (output valid, command, row, column, value, flag_a, flag_b,
                  cursor_mode, input ready);
  modport sink (input valid, command, row, column, value, flag_a, flag_b,
                cursor_mode, output ready);
endinterface

interface clcd_phase_if;
  logic        valid;
  logic        ready;
  logic        register_select;
  logic        enable;
  logic [3:0]  nibble;
  logic [22:0] hold_time;
  logic        last;

  modport source (output valid, register_select, enable, nibble, hold_time,
                  last, input ready);
  modport sink (input valid, register_select, enable, nibble, hold_time, last,
                output ready);
endinterface

// ===== sv/clcd_front.sv =====
// ----------------------------------------------------------------------------
// Character LCD request decoder
// Accepts requests, builds the instruction byte and queues a job; requests
// that produce no bus traffic are taken and dropped.
// ----------------------------------------------------------------------------
module clcd_front #(
  parameter int COLUMNS = clcd_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = clcd_pkg::ROWS_DEFAULT
) (
  clcd_req_if.sink      req,
  input  logic          full,
  output logic          push,
  output clcd_pkg::job_t push_job
);
  import clcd_pkg::*;

  localparam logic [5:0] ColMax = 6'(COLUMNS);
  localparam logic [2:0] RowMax = 3'(ROWS);

  logic       keep;
  logic       pos_ok;
  logic [1:0] row_idx;
  logic [6:0] pos_addr;

  // Screen position to DDRAM address.
  assign pos_ok = (req.row != 3'd0) && (req.row <= RowMax) &&
                  (req.column != 5'd0) && ({1'b0, req.column} <= ColMax);
  assign row_idx = 2'(req.row - 3'd1);
  assign pos_addr = 7'({2'b00, req.column}) - 7'd1 + row_offset(row_idx);

  // Classify the request into a queue entry.
  always_comb begin
    push_job = '0;
    keep = 1'b1;
    unique case (cmd_t'(req.command))
      CMD_INIT: begin
        push_job.init = 1'b1;
        push_job.data = INS_DISPLAY_ON | {6'b0, req.cursor_mode};
      end
      CMD_CLEAR: begin
        push_job.data = INS_CLEAR;
        push_job.clear_wait = 1'b1;
      end
      CMD_HOME: push_job.data = INS_HOME;
      CMD_ENTRY: push_job.data = INS_ENTRY | {6'b0, req.flag_a, req.flag_b};
      CMD_DISPLAY: push_job.data = INS_DISPLAY | {5'b0, req.flag_a, req.cursor_mode};
      CMD_CURSOR_SHIFT: push_job.data = INS_CURSOR_SHIFT | {5'b0, req.flag_a, 2'b00};
      CMD_DISPLAY_SHIFT: push_job.data = INS_DISPLAY_SHIFT | {5'b0, req.flag_a, 2'b00};
      CMD_POSITION: begin
        keep = pos_ok;
        push_job.data = INS_DDRAM | {1'b0, pos_addr};
      end
      CMD_DDRAM: push_job.data = INS_DDRAM | {1'b0, req.value[6:0]};
      CMD_CGRAM: begin
        keep = (req.value[7:3] == 5'd0);
        push_job.data = INS_CGRAM | {2'b00, req.value[2:0], 3'b000};
      end
      CMD_DATA: begin
        push_job.rs = 1'b1;
        push_job.data = req.value;
      end
      CMD_FUNCTION_SET: push_job.data = INS_FUNCTION_SET;
      default: keep = 1'b0;
    endcase
  end

  assign req.ready = !full;
  assign push = req.valid && !full && keep;

endmodule

// ===== sv/clcd_queue.sv =====
// ----------------------------------------------------------------------------
// Character LCD job queue
// Short register queue between the decoder and the bus sequencer.
// ----------------------------------------------------------------------------
module clcd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  clcd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output clcd_pkg::job_t q_job
);
  import clcd_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  job_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [CntW-1:0] count;
  logic            do_pop;

  assign full = (count == CntFull);
  assign q_valid = (count != '0);
  assign q_job = entries[rptr];
  assign do_pop = pop && q_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PtrLast) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PtrLast) ? '0 : rptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/clcd_back.sv =====
// ----------------------------------------------------------------------------
// Character LCD bus sequencer
// Holds the timing registers and turns each queued job into enable phases,
// one phase per cycle into a registered output stage while that stage is not stalled.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_command_sequencer_defines.svh"

module clcd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [clcd_pkg::TICK_W-1:0]  cfg_data,
  input  logic                         q_valid,
  input  clcd_pkg::job_t               q_job,
  output logic                         q_pop,
  clcd_phase_if.source                 phase
);
  import clcd_pkg::*;

  logic [TICK_W-1:0] pulse_ticks;
  logic [TICK_W-1:0] command_ticks;
  logic [TICK_W-1:0] clear_ticks;

  job_t              job;
  logic              active;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] last_step;
  logic [STEP_W-1:0] byte_step;
  logic              emit;
  logic              is_last;

  logic              ph_en;
  logic [3:0]        ph_nibble;
  logic              ph_extra;
  logic              ph_clear;
  logic [7:0]        ph_byte;
  logic [HOLD_W-1:0] ph_hold;

  logic              out_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks <= PULSE_RESET;
      command_ticks <= COMMAND_RESET;
      clear_ticks <= CLEAR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PULSE: pulse_ticks <= cfg_data;
        REG_COMMAND: command_ticks <= cfg_data;
        REG_CLEAR: clear_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign last_step = job.init ? INIT_LAST_STEP : BYTE_LAST_STEP;
  assign is_last = (step == last_step);
  assign emit = active && (!out_valid || phase.ready);
  assign q_pop = !active || (emit && is_last);
  assign byte_step = step - WAKE_PHASES;

  // Phase contents for the current step.
  always_comb begin
    ph_byte = job.data;
    ph_clear = job.clear_wait;
    if (job.init && (step < WAKE_PHASES)) begin
      ph_en = !step[0];
      ph_nibble = (step[2:1] == 2'd3) ? NIB_WAKE_LAST : NIB_WAKE;
      ph_extra = step[0];
      ph_clear = 1'b0;
    end else begin
      if (job.init) begin
        unique case (byte_step[3:2])
          2'd0: ph_byte = INS_FUNCTION_SET;
          2'd1: ph_byte = job.data;
          2'd2: ph_byte = INS_CLEAR;
          2'd3: ph_byte = INS_ENTRY_INIT;
          default: ph_byte = job.data;
        endcase
        ph_clear = (byte_step[3:2] == INIT_CLEAR_SLOT);
      end
      ph_en = !step[0];
      ph_nibble = step[1] ? ph_byte[3:0] : ph_byte[7:4];
      ph_extra = (step[1:0] == 2'd3);
    end
    ph_hold = {1'b0, pulse_ticks};
    if (ph_extra) begin
      ph_hold = {1'b0, pulse_ticks} + {1'b0, (ph_clear ? clear_ticks : command_ticks)};
    end
  end

  // Job register and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step <= '0;
    end else begin
      if (q_pop && q_valid) begin
        active <= 1'b1;
        step <= '0;
      end else if (emit && is_last) begin
        active <= 1'b0;
      end else if (emit) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_valid) begin
      job <= q_job;
    end
  end

  // Output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (phase.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      phase.register_select <= job.rs;
      phase.enable <= ph_en;
      phase.nibble <= ph_nibble;
      phase.hold_time <= ph_hold;
      phase.last <= is_last;
    end
  end

  assign phase.valid = out_valid;

  `CLCD_ASSERT_NOW(a_step_range, active, step <= last_step, "step beyond job end")
  `CLCD_ASSERT_NEXT(a_load_start, q_pop && q_valid, active && (step == '0), "job load did not restart")
  `CLCD_ASSERT_NEXT(a_idle_after, emit && is_last && !q_valid, !active, "job stayed active after last phase")

endmodule

// ===== sv/char_lcd_nibble_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble command sequencer
// Turns display requests into 4-bit enable bus phases with hold times.
// ----------------------------------------------------------------------------
// An accepted request passes the queue entry, the job register and the registered output stage.
// Throughput: one phase per cycle from the bus sequencer while the phase output is not stalled;
// a byte request is 4 phases and init is 24, as set by the step counter of the sequencer.
// Requests are taken while a two-entry job queue has room.
// Reset: synchronous; clears the queue and output, and loads 500, 50000 and 1500000 ticks.
module char_lcd_nibble_command_sequencer #(
  parameter int COLUMNS = clcd_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = clcd_pkg::ROWS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [clcd_pkg::TICK_W-1:0] cfg_data,
  clcd_req_if.sink                    req,
  clcd_phase_if.source                phase
);
  import clcd_pkg::*;

  logic full;
  logic push;
  job_t push_job;
  logic q_pop;
  logic q_valid;
  job_t q_job;

  // Request decoder.
  clcd_front #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_front (
    .req(req),
    .full(full),
    .push(push),
    .push_job(push_job)
  );

  // Job queue.
  clcd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .full(full),
    .pop(q_pop),
    .q_valid(q_valid),
    .q_job(q_job)
  );

  // Bus phase sequencer.
  clcd_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_valid(q_valid),
    .q_job(q_job),
    .q_pop(q_pop),
    .phase(phase)
  );

endmodule
